@@ design/command_line_argv_env_builder_defines.svh @@
// Assertion macros for the command line builder.
`ifndef COMMAND_LINE_ARGV_ENV_BUILDER_DEFINES_SVH
`define COMMAND_LINE_ARGV_ENV_BUILDER_DEFINES_SVH
`ifndef SYNTHESIS
`define CLB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CLB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CLB_ASSERT(label, clk, rst_n, prop, msg)
`define CLB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

@@ design/clb_pkg.sv @@
// ----------------------------------------------------------------------------
// clb_pkg
// Shared constants and types of the command line and environment builder.
// ----------------------------------------------------------------------------
package clb_pkg;
    localparam int TEXT_BYTES  = 4096;
    localparam int MAX_STRINGS = 64;
    localparam int TW = $clog2(TEXT_BYTES);
    localparam int SW = $clog2(MAX_STRINGS);
    localparam int LW = 13;
    localparam int CW = 7;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_LINE  = 3'd1;
    localparam logic [2:0] OP_ENV   = 3'd2;
    localparam logic [2:0] OP_FIN   = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LIMIT   = 2'd1;
    localparam logic [1:0] ST_PRECOND = 2'd2;

    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_QUO = 8'h22;
    localparam logic [7:0] CH_SPC = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  char_byte;
        logic [12:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  arg_count;
        logic [6:0]  env_count;
        logic [12:0] image_bytes;
        logic [31:0] argv_address;
        logic [31:0] envp_address;
        logic [7:0]  image_byte;
    } t_out;

    // Offset table access between the control unit and the table memory.
    typedef struct packed {
        logic          we;
        logic          env_sel;
        logic [SW-1:0] waddr;
        logic [LW-1:0] wdata;
        logic [SW-1:0] raddr;
        logic          renv;
    } t_tab_req;
endpackage

@@ design/clb_if.sv @@
// ----------------------------------------------------------------------------
// clb_in_if / clb_out_if
// Valid-ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface clb_in_if;
    logic          valid;
    logic          ready;
    clb_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface clb_out_if;
    logic          valid;
    logic          ready;
    clb_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/clb_text_ram.sv @@
// ----------------------------------------------------------------------------
// clb_text_ram
// Text store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module clb_text_ram (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [clb_pkg::TW-1:0] i_waddr,
    input  logic [7:0]           i_wdata,
    input  logic [clb_pkg::TW-1:0] i_raddr,
    output logic [7:0]           o_rdata
);
    import clb_pkg::*;
    logic [7:0] mem [TEXT_BYTES];

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ design/clb_offset_tab.sv @@
// ----------------------------------------------------------------------------
// clb_offset_tab
// Argument and environment offset tables with registered read.
// ----------------------------------------------------------------------------
module clb_offset_tab (
    input  logic                    i_clk,
    input  clb_pkg::t_tab_req       i_req,
    output logic [clb_pkg::LW-1:0]  o_rdata
);
    import clb_pkg::*;
    logic [LW-1:0] arg_mem [MAX_STRINGS];
    logic [LW-1:0] env_mem [MAX_STRINGS];

    // One write to either table, read of the selected table.
    always_ff @(posedge i_clk) begin
        if (i_req.we && !i_req.env_sel) begin
            arg_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.we && i_req.env_sel) begin
            env_mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= i_req.renv ? env_mem[i_req.raddr] : arg_mem[i_req.raddr];
    end
endmodule

@@ design/command_line_argv_env_builder.sv @@
// ----------------------------------------------------------------------------
// command_line_argv_env_builder
// Splits a command line into arguments, stores environment strings, builds
// the argv/envp image and reads it back one byte at a time.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  i_cmd    | in  | operation, char_byte, read_index
//  o_res    | out | status, counts, image size, addresses, image byte
//  cfg      | in  | base_address (0), capacity_bytes (1)
//
// A beat is taken in the idle state, executed in S_EXEC and presented in S_OUT.
// A read passes through S_RD1 and S_RD2 for the registered offset table and
// text store reads. A backslash run ended by another byte writes each stored
// backslash in its own flush step, then executes the held byte; a run ended by
// a quote writes half the run, then a literal quote if the run was odd. An
// environment or finish beat that must first end an open line runs a second
// execute step. Reset is synchronous; the stores hold no reset value. A
// stalled result holds the block; the input is taken only when the result
// slot is free.
// ----------------------------------------------------------------------------
`include "command_line_argv_env_builder_defines.svh"
module command_line_argv_env_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    clb_in_if.sink      i_cmd,
    clb_out_if.source   o_res
);
    import clb_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_FLUSH, S_RD1, S_RD2, S_OUT
    } t_state;

    localparam int RW = LW + 1;

    localparam logic [1:0] PH_ARG0 = 2'd0;
    localparam logic [1:0] PH_ARGN = 2'd1;
    localparam logic [1:0] PH_GAP  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [1:0] AFT_RESUME = 2'd0;
    localparam logic [1:0] AFT_DONE   = 2'd1;
    localparam logic [1:0] AFT_QUOTE  = 2'd2;

    localparam logic [1:0] RK_ZERO = 2'd0;
    localparam logic [1:0] RK_TAB  = 2'd1;
    localparam logic [1:0] RK_TEXT = 2'd2;

    t_state       r_state;
    logic [31:0]  r_base;
    logic [15:0]  r_cap;
    t_in          r_cmd;
    logic [LW-1:0] r_len;
    logic [CW-1:0] r_args, r_envs;
    logic [RW-1:0] r_run;
    logic         r_quoted, r_qpend, r_env_open;
    logic [1:0]   r_phase, r_err;
    logic [RW-1:0] r_flush_n;    // backslashes left to write
    logic [1:0]   r_after;       // what follows the backslash flush
    logic         r_fin;         // line already ended; env or finish step remains
    logic [1:0]   r_rd_kind;
    logic [31:0]  r_rd_extra;
    logic [1:0]   r_rd_sh;
    logic [7:0]   r_obyte;
    t_out         r_out;

    logic         t_we;
    logic [TW-1:0] t_wa, t_ra;
    logic [7:0]   t_wd, t_rd;
    t_tab_req     tab;
    logic [LW-1:0] tab_rd;

    clb_text_ram u_text (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_wa), .i_wdata(t_wd),
        .i_raddr(t_ra), .o_rdata(t_rd)
    );
    clb_offset_tab u_tab (.i_clk(i_clk), .i_req(tab), .o_rdata(tab_rd));

    // Step working copies.
    logic [LW-1:0] n_len;
    logic [RW-1:0] n_run, n_flush_n;
    logic [CW-1:0] n_args, n_envs;
    logic          n_quoted, n_qpend, n_env_open, n_fin;
    logic [1:0]    n_phase, n_err, n_after;
    t_state        n_state;
    logic [LW-1:0] tables;
    logic [13:0]   total;
    logic [LW-1:0] rel;

    assign tables = LW'((r_args + r_envs + 2) * 4);
    assign total  = 14'(tables) + 14'(r_len);

    function automatic logic blank(input logic [7:0] c);
        return c == CH_SPC || c == CH_TAB;
    endfunction

    // Decode and execute one beat, or one flush step.
    always_comb begin
        logic [7:0] c;
        logic       wr;
        logic [7:0] wc;
        logic       endarg, endlast, gapopen, doenv, fin_go;
        c = r_cmd.char_byte;
        n_len = r_len; n_run = r_run; n_args = r_args; n_envs = r_envs;
        n_quoted = r_quoted; n_qpend = r_qpend; n_env_open = r_env_open;
        n_phase = r_phase; n_err = r_err; n_flush_n = r_flush_n; n_fin = r_fin;
        n_after = r_after;
        n_state = r_state;
        wr = 1'b0; wc = 8'h00; endarg = 1'b0; endlast = 1'b0; gapopen = 1'b0;
        doenv = 1'b0; fin_go = 1'b0;
        tab = '0;
        rel = r_cmd.read_index - tables;
        t_ra = rel[TW-1:0];
        tab.renv = !(LW'(r_cmd.read_index[LW-1:2]) < LW'(r_args));
        tab.raddr = tab.renv ?
            SW'(LW'(r_cmd.read_index[LW-1:2]) - LW'(r_args) - LW'(1)) :
            r_cmd.read_index[SW+1:2];
        if (r_state == S_FLUSH) begin
            if (r_flush_n != 0 && r_err == ST_OK) begin
                // Write one stored backslash.
                wr = 1'b1; wc = CH_BSL; n_flush_n = r_flush_n - 1'b1;
            end else begin
                // Run written: finish the quote, or resume the held byte.
                n_flush_n = '0;
                if (r_err != ST_OK || r_after == AFT_DONE) begin
                    n_state = S_OUT;
                end else if (r_after == AFT_QUOTE) begin
                    wr = 1'b1; wc = CH_QUO; n_state = S_OUT;
                end else begin
                    n_state = S_EXEC;
                end
            end
        end else if (r_state == S_EXEC) begin
            n_state = S_OUT;
            case (r_cmd.operation)
                OP_START: begin
                    n_len = '0; n_run = '0; n_args = '0; n_envs = '0;
                    n_quoted = 1'b0; n_qpend = 1'b0; n_env_open = 1'b0;
                    n_phase = PH_ARG0; n_err = ST_OK;
                end
                OP_LINE, OP_ENV, OP_FIN: begin
                    if (r_err == ST_OK) begin
                        logic [7:0] lc;
                        logic       line_step;
                        // Env and finish first end the line with a zero byte.
                        line_step = r_cmd.operation == OP_LINE ||
                            r_phase == PH_ARG0 || r_phase == PH_ARGN;
                        lc = r_cmd.operation == OP_LINE ? c : 8'h00;
                        if (r_cmd.operation != OP_LINE && r_phase == PH_GAP) begin
                            n_phase = PH_DONE;
                        end
                        if (line_step && !r_fin) begin
                            case (r_phase)
                                PH_ARG0: begin
                                    if (lc == 0 || (!r_quoted && blank(lc))) begin
                                        endarg = 1'b1; endlast = lc == 0;
                                    end else if (lc == CH_QUO) begin
                                        n_quoted = !r_quoted;
                                    end else begin
                                        wr = 1'b1; wc = lc;
                                    end
                                end
                                PH_ARGN, PH_GAP: begin
                                    logic go;
                                    logic q, qp;
                                    logic [RW-1:0] run;
                                    go = 1'b1; q = r_quoted; qp = r_qpend; run = r_run;
                                    if (r_phase == PH_GAP) begin
                                        if (blank(lc)) begin
                                            go = 1'b0;
                                        end else if (lc == 0) begin
                                            go = 1'b0; n_phase = PH_DONE;
                                        end else if (r_args >= CW'(MAX_STRINGS)) begin
                                            go = 1'b0; n_err = ST_LIMIT;
                                        end else begin
                                            gapopen = 1'b1; n_phase = PH_ARGN;
                                            q = 1'b0; qp = 1'b0; run = '0;
                                        end
                                    end
                                    if (go) begin
                                        if (run != 0) begin
                                            if (lc == CH_BSL) begin
                                                go = 1'b0;
                                                n_run = run + 1'b1;
                                                if (LW'(n_run >> 1) >
                                                    LW'(TEXT_BYTES) - r_len) begin
                                                    n_err = ST_LIMIT;
                                                end
                                            end else if (lc == CH_QUO) begin
                                                // Half the run, then a literal
                                                // quote or a quote toggle.
                                                go = 1'b0; n_run = '0;
                                                n_flush_n = run >> 1;
                                                n_state = S_FLUSH;
                                                if (run[0]) begin
                                                    n_after = AFT_QUOTE;
                                                end else begin
                                                    n_after = AFT_DONE;
                                                    if (q) n_qpend = 1'b1;
                                                    else n_quoted = 1'b1;
                                                end
                                            end else begin
                                                go = 1'b0; n_run = '0;
                                                n_flush_n = run; n_after = AFT_RESUME;
                                                n_state = S_FLUSH;
                                            end
                                        end else if (qp) begin
                                            n_qpend = 1'b0;
                                            if (lc == CH_QUO) begin
                                                go = 1'b0; wr = 1'b1; wc = CH_QUO;
                                            end else begin
                                                q = 1'b0; n_quoted = 1'b0;
                                            end
                                        end
                                    end
                                    if (go) begin
                                        n_quoted = q; n_qpend = 1'b0;
                                        if (lc == 0 || (!q && blank(lc))) begin
                                            endarg = 1'b1; endlast = lc == 0;
                                        end else if (lc == CH_BSL) begin
                                            n_run = RW'(1);
                                        end else if (lc == CH_QUO) begin
                                            if (q) n_qpend = 1'b1; else n_quoted = 1'b1;
                                        end else begin
                                            wr = 1'b1; wc = lc;
                                        end
                                    end
                                end
                                default: ;
                            endcase
                        end else begin
                            fin_go = 1'b1;
                        end
                        if (r_cmd.operation == OP_ENV && fin_go) doenv = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        // Argument end writes a zero byte.
        if (endarg) begin
            wr = 1'b1; wc = 8'h00;
        end
        if (gapopen) begin
            tab.we = 1'b1; tab.env_sel = 1'b0; tab.waddr = SW'(r_args); tab.wdata = r_len;
        end
        if (doenv) begin
            if (!r_env_open && c == 0) begin
                wr = 1'b0;
            end else if (!r_env_open && r_envs >= CW'(MAX_STRINGS)) begin
                n_err = ST_LIMIT;
            end else begin
                if (!r_env_open) begin
                    tab.we = 1'b1; tab.env_sel = 1'b1;
                    tab.waddr = SW'(r_envs); tab.wdata = r_len;
                end
                n_env_open = 1'b1; wr = 1'b1; wc = c;
            end
        end
        if (fin_go && r_cmd.operation == OP_FIN && r_env_open) begin
            wr = 1'b1; wc = 8'h00;
        end
        // Text append with overflow check.
        t_we = 1'b0; t_wa = r_len[TW-1:0]; t_wd = wc;
        if (wr) begin
            if (r_len >= LW'(TEXT_BYTES)) begin
                n_err = ST_LIMIT;
            end else begin
                t_we = 1'b1; n_len = r_len + 1'b1;
                if (endarg) begin
                    n_args = r_args + 1'b1; n_quoted = 1'b0; n_qpend = 1'b0;
                    n_run = '0; n_phase = endlast ? PH_DONE : PH_GAP;
                end
                if (doenv && wc == 0) begin
                    n_env_open = 1'b0; n_envs = r_envs + 1'b1;
                end
                if (fin_go && r_cmd.operation == OP_FIN && r_env_open) begin
                    n_env_open = 1'b0; n_envs = r_envs + 1'b1;
                end
            end
        end
        // Finish checks on the completed image.
        if (fin_go && r_cmd.operation == OP_FIN && n_err == ST_OK &&
            !(r_env_open && !t_we)) begin
            logic [LW-1:0] tb;
            logic [32:0]   sum;
            tb = LW'((n_args + n_envs + 2) * 4);
            sum = 33'(r_base) + 33'(tb) + 33'(n_len);
            if (r_base == 0) begin
                n_err = ST_PRECOND;
            end else if (17'(tb) + 17'(n_len) > 17'(r_cap) || sum > 33'h100000000) begin
                n_err = ST_LIMIT;
            end
        end
        if (r_state == S_EXEC && (r_cmd.operation == OP_FIN || r_cmd.operation == OP_ENV)
            && !fin_go && r_err == ST_OK && n_state != S_FLUSH) begin
            // Line was ended this cycle; run the environment or finish step next.
            n_fin = 1'b1; n_state = S_EXEC;
        end
        if (r_state == S_EXEC && r_cmd.operation == OP_READ) begin
            n_state = S_RD1;
        end
        if (n_state == S_OUT) n_fin = 1'b0;
    end

    assign i_cmd.ready = r_state == S_IDLE;
    assign o_res.valid = r_state == S_OUT;
    assign o_res.data  = r_out;

    // Control state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_base <= '0; r_cap <= 16'hFFFF;
            r_len <= '0; r_args <= '0; r_envs <= '0; r_run <= '0;
            r_quoted <= 1'b0; r_qpend <= 1'b0; r_env_open <= 1'b0;
            r_phase <= PH_ARG0; r_err <= ST_OK; r_flush_n <= '0; r_fin <= 1'b0;
            r_after <= AFT_RESUME;
        end else begin
            if (i_cfg_we && !i_cfg_index) r_base <= i_cfg_data;
            if (i_cfg_we && i_cfg_index)  r_cap <= i_cfg_data[15:0];
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        r_cmd <= i_cmd.data; r_state <= S_EXEC;
                    end
                end
                S_EXEC, S_FLUSH: begin
                    r_len <= n_len; r_run <= n_run; r_args <= n_args; r_envs <= n_envs;
                    r_quoted <= n_quoted; r_qpend <= n_qpend; r_env_open <= n_env_open;
                    r_phase <= n_phase; r_err <= n_err; r_flush_n <= n_flush_n;
                    r_fin <= n_fin; r_after <= n_after;
                    r_state <= n_state;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                    r_rd_sh <= r_cmd.read_index[1:0];
                    r_rd_extra <= r_base + 32'(tables);
                    if (r_err != ST_OK || 14'(r_cmd.read_index) >= total) r_rd_kind <= RK_ZERO;
                    else if (r_cmd.read_index >= tables) r_rd_kind <= RK_TEXT;
                    else if (LW'(r_cmd.read_index[LW-1:2]) < LW'(r_args) ||
                             (LW'(r_cmd.read_index[LW-1:2]) > LW'(r_args) &&
                              LW'(r_cmd.read_index[LW-1:2]) <
                              LW'(r_args) + LW'(r_envs) + 1'b1))
                        r_rd_kind <= RK_TAB;
                    else r_rd_kind <= RK_ZERO;
                end
                S_RD2: begin
                    logic [31:0] v;
                    v = (r_rd_extra + 32'(tab_rd)) >> {r_rd_sh, 3'b000};
                    case (r_rd_kind)
                        RK_TAB:  r_obyte <= v[7:0];
                        RK_TEXT: r_obyte <= t_rd;
                        default: r_obyte <= 8'h00;
                    endcase
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result fields follow the live state; image byte only for reads.
    always_comb begin
        r_out.status       = r_err;
        r_out.arg_count    = r_args;
        r_out.env_count    = r_envs;
        r_out.image_bytes  = total[LW-1:0];
        r_out.argv_address = r_base;
        r_out.envp_address = r_base + 32'((r_args + 1) * 4);
        r_out.image_byte   = r_cmd.operation == OP_READ ? r_obyte : 8'h00;
    end

    `CLB_ASSERT(a_one_side, i_clk, i_rst_n, !(i_cmd.ready && o_res.valid), "ready with result")
    `CLB_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready, o_res.valid, "result lost")
    `CLB_ASSERT(a_len, i_clk, i_rst_n, r_len <= LW'(TEXT_BYTES), "text overrun")
endmodule

@@ dv/command_line_argv_env_builder_tb.sv @@
// ----------------------------------------------------------------------------
// command_line_argv_env_builder_tb
// Drives command beats into the argv/envp image builder and checks every
// result beat against a cycle-free predictor of the parser and image layout.
// ----------------------------------------------------------------------------
module command_line_argv_env_builder_tb;
    import clb_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_CAP  = 1'b1;

    typedef enum logic [1:0] {PH_ARG0, PH_ARGN, PH_GAP, PH_DONE} t_phase;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_index;
    logic [31:0] i_cfg_data;

    clb_in_if  cmd_if ();
    clb_out_if res_if ();

    command_line_argv_env_builder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd_if.sink),
        .o_res       (res_if.source)
    );

    // Predictor state.
    logic [31:0] pm_base;
    logic [15:0] pm_cap;
    logic [7:0]  pm_text [TEXT_BYTES];
    int          pm_arg_off [MAX_STRINGS];
    int          pm_env_off [MAX_STRINGS];
    int          pm_len, pm_args, pm_envs, pm_slashes;
    bit          pm_quoted, pm_qpend, pm_env_open;
    t_phase      pm_phase;
    logic [1:0]  pm_status;

    t_out        expected_beats [$];
    int          cycle_count;
    int          mismatches;
    int          beats_seen;

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPC || c == CH_TAB;
    endfunction

    function automatic void clear_image();
        pm_len = 0; pm_args = 0; pm_envs = 0; pm_slashes = 0;
        pm_quoted = 0; pm_qpend = 0; pm_env_open = 0;
        pm_phase = PH_ARG0; pm_status = ST_OK;
    endfunction

    function automatic bit put_text(logic [7:0] c);
        if (pm_status != ST_OK) return 0;
        if (pm_len >= TEXT_BYTES) begin
            pm_status = ST_LIMIT;
            return 0;
        end
        pm_text[pm_len] = c;
        pm_len++;
        return 1;
    endfunction

    function automatic void put_slashes(int n);
        for (int i = 0; i < n; i++)
            if (!put_text(CH_BSL)) return;
    endfunction

    function automatic void end_argument(bit last);
        if (!put_text(8'h00)) return;
        pm_args++;
        pm_quoted = 0; pm_qpend = 0; pm_slashes = 0;
        pm_phase = last ? PH_DONE : PH_GAP;
    endfunction

    // Backslash and quote rules for arguments after the first.
    function automatic void later_arg_char(logic [7:0] c);
        int run;
        bit ok;
        if (pm_slashes != 0) begin
            if (c == CH_BSL) begin
                pm_slashes++;
                if (pm_slashes / 2 > TEXT_BYTES - pm_len) pm_status = ST_LIMIT;
                return;
            end
            run = pm_slashes;
            pm_slashes = 0;
            if (c == CH_QUO) begin
                put_slashes(run / 2);
                if (run % 2) begin
                    ok = put_text(CH_QUO);
                    return;
                end
                if (pm_quoted) pm_qpend = 1; else pm_quoted = 1;
                return;
            end
            put_slashes(run);
            if (pm_status != ST_OK) return;
        end else if (pm_qpend) begin
            pm_qpend = 0;
            if (c == CH_QUO) begin
                ok = put_text(CH_QUO);
                return;
            end
            pm_quoted = 0;
        end
        if (c == 0 || (!pm_quoted && is_blank(c))) begin
            end_argument(c == 0);
            return;
        end
        if (c == CH_BSL) begin
            pm_slashes = 1;
            return;
        end
        if (c == CH_QUO) begin
            if (pm_quoted) pm_qpend = 1; else pm_quoted = 1;
            return;
        end
        ok = put_text(c);
    endfunction

    function automatic void line_char(logic [7:0] c);
        bit ok;
        case (pm_phase)
            PH_ARG0: begin
                if (c == 0 || (!pm_quoted && is_blank(c))) end_argument(c == 0);
                else if (c == CH_QUO) pm_quoted = !pm_quoted;
                else ok = put_text(c);
            end
            PH_ARGN: later_arg_char(c);
            PH_GAP: begin
                if (is_blank(c)) return;
                if (c == 0) begin
                    pm_phase = PH_DONE;
                    return;
                end
                if (pm_args >= MAX_STRINGS) begin
                    pm_status = ST_LIMIT;
                    return;
                end
                pm_arg_off[pm_args] = pm_len;
                pm_phase = PH_ARGN;
                pm_quoted = 0; pm_qpend = 0; pm_slashes = 0;
                later_arg_char(c);
            end
            default: ;
        endcase
    endfunction

    function automatic void close_line();
        if (pm_phase == PH_ARG0 || pm_phase == PH_ARGN) line_char(8'h00);
        else pm_phase = PH_DONE;
    endfunction

    function automatic void env_char(logic [7:0] c);
        if (pm_phase != PH_DONE) close_line();
        if (pm_status != ST_OK) return;
        if (!pm_env_open) begin
            if (c == 0) return;
            if (pm_envs >= MAX_STRINGS) begin
                pm_status = ST_LIMIT;
                return;
            end
            pm_env_off[pm_envs] = pm_len;
            pm_env_open = 1;
        end
        if (!put_text(c)) return;
        if (c == 0) begin
            pm_env_open = 0;
            pm_envs++;
        end
    endfunction

    function automatic void finish_image();
        longint total;
        if (pm_phase != PH_DONE) close_line();
        if (pm_status != ST_OK) return;
        if (pm_env_open) begin
            if (!put_text(8'h00)) return;
            pm_env_open = 0;
            pm_envs++;
        end
        if (pm_base == 0) begin
            pm_status = ST_PRECOND;
            return;
        end
        total = (pm_args + pm_envs + 2) * 4 + pm_len;
        if (total > pm_cap || longint'(pm_base) + total > 64'h1_0000_0000)
            pm_status = ST_LIMIT;
    endfunction

    function automatic logic [7:0] image_at(int idx);
        int tables, word;
        logic [31:0] v;
        tables = (pm_args + pm_envs + 2) * 4;
        if (pm_status != ST_OK || idx >= tables + pm_len) return 8'h00;
        if (idx >= tables) return pm_text[idx - tables];
        word = idx / 4;
        if (word < pm_args)
            v = pm_base + tables + pm_arg_off[word];
        else if (word > pm_args && word < pm_args + 1 + pm_envs)
            v = pm_base + tables + pm_env_off[word - pm_args - 1];
        else
            v = 0;
        return 8'(v >> (8 * (idx % 4)));
    endfunction

    // Applies one command beat to the predictor and returns the expected result.
    function automatic t_out predict_result(t_in c);
        t_out r;
        r.image_byte = 8'h00;
        case (c.operation)
            OP_START: clear_image();
            OP_LINE:  if (pm_status == ST_OK) line_char(c.char_byte);
            OP_ENV:   if (pm_status == ST_OK) env_char(c.char_byte);
            OP_FIN:   if (pm_status == ST_OK) finish_image();
            OP_READ:  r.image_byte = image_at(c.read_index);
            default: ;
        endcase
        r.status       = pm_status;
        r.arg_count    = 7'(pm_args);
        r.env_count    = 7'(pm_envs);
        r.image_bytes  = 13'((pm_args + pm_envs + 2) * 4 + pm_len);
        r.argv_address = pm_base;
        r.envp_address = pm_base + 32'((pm_args + 1) * 4);
        return r;
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Cycle counter and timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: stalls on its own pattern, checks at the rising edge.
    logic [7:0] stall_pattern;
    initial begin
        res_if.ready = 1'b0;
        stall_pattern = 8'hFF;
        forever begin
            @(negedge i_clk);
            if (($urandom % 64) == 0) stall_pattern = 8'($urandom);
            if (($urandom % 5) == 0) stall_pattern = 8'hFF;
            res_if.ready <= stall_pattern[cycle_count % 8];
        end
    end

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result beat %p", res_if.data);
            end else begin
                exp_r = expected_beats.pop_front();
                if (res_if.data !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch at cycle %0d: expected %p actual %p",
                            cycle_count, exp_r, res_if.data);
                end
            end
        end
    end

    task automatic write_register(logic idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_BASE) pm_base = value;
        else pm_cap = value[15:0];
    endtask

    // Sends one beat, predicting it at acceptance.
    int burst_left;
    task automatic send_beat(t_in c);
        if (burst_left == 0) begin
            int gap;
            gap = $urandom_range(0, 4);
            if (gap != 0) begin
                cmd_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        cmd_if.valid <= 1'b1;
        cmd_if.data <= c;
        do @(posedge i_clk); while (!cmd_if.ready);
        expected_beats.push_back(predict_result(c));
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [2:0] op, logic [7:0] ch, logic [12:0] idx = 0);
        t_in c;
        c.operation = op;
        c.char_byte = ch;
        c.read_index = idx;
        send_beat(c);
    endtask

    // Waits until the block is idle before a register write.
    task automatic drain_results();
        cmd_if.valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic send_string(string s, logic [2:0] op);
        for (int i = 0; i < s.len(); i++) send_op(op, s[i]);
    endtask

    function automatic logic [7:0] random_char();
        case ($urandom % 8)
            0: return CH_BSL;
            1: return CH_QUO;
            2: return ($urandom % 2) ? CH_SPC : CH_TAB;
            3: return ($urandom % 16 == 0) ? 8'h00 : 8'h41;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    // One well-formed session: line, environment, finish, reads.
    task automatic run_session(int size);
        int n;
        send_op(OP_START, 8'($urandom));
        n = $urandom_range(0, size);
        for (int i = 0; i < n; i++) send_op(OP_LINE, random_char());
        if ($urandom % 4) send_op(OP_LINE, 8'h00);
        n = $urandom_range(0, size);
        for (int i = 0; i < n; i++)
            send_op(OP_ENV, ($urandom % 6 == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        if ($urandom % 8) send_op(OP_FIN, 8'($urandom));
        n = $urandom_range(2, 12);
        for (int i = 0; i < n; i++)
            send_op(OP_READ, 8'($urandom), ($urandom % 8 == 0) ? 13'($urandom) :
                13'($urandom_range(0, 2 * size + 40)));
        // Occasional noise: undefined operations.
        if ($urandom % 10 == 0)
            send_op(3'($urandom_range(5, 7)), 8'($urandom), 13'($urandom));
    endtask

    typedef struct {
        t_in  cmd;
        bit   typed;
        t_out want;
    } t_row;

    t_row directed_rows [$];

    function automatic void add_row(logic [2:0] op, logic [7:0] ch, logic [12:0] idx);
        t_row r;
        r.cmd = '{op, ch, idx};
        r.typed = 0;
        directed_rows.push_back(r);
    endfunction

    initial begin
        t_row row;
        t_out got;
        string line_text;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = '0;
        cmd_if.valid = 1'b0;
        cmd_if.data = '0;
        mismatches = 0;
        beats_seen = 0;
        burst_left = 0;
        pm_base = 0;
        pm_cap = 16'hFFFF;
        clear_image();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: finish with base zero gives a precondition error.
        row.cmd = '{OP_FIN, 8'h00, 13'd0};
        row.typed = 1;
        row.want = '{ST_PRECOND, 7'd1, 7'd0, 13'd13, 32'd0, 32'd8, 8'd0};
        directed_rows.push_back(row);
        row.cmd = '{OP_READ, 8'hFF, 13'h1FFF};
        row.want.image_byte = 8'd0;
        directed_rows.push_back(row);
        add_row(OP_START, 8'h00, 13'd0);
        line_text = " \"a b\"\\\\\\\"x \"q\"\"r\" \\\\\" ";
        for (int i = 0; i < line_text.len(); i++) add_row(OP_LINE, line_text[i], 0);
        add_row(OP_ENV, 8'h00, 0);
        add_row(OP_ENV, 8'hFF, 0);
        add_row(OP_ENV, 8'h00, 0);
        add_row(OP_LINE, 8'h41, 0);
        add_row(OP_FIN, 8'h00, 0);
        for (int i = 0; i < directed_rows.size(); i++) begin
            if (directed_rows[i].typed) begin
                got = predict_result(directed_rows[i].cmd);
                if (got !== directed_rows[i].want) begin
                    mismatches++;
                    $display("Directed row %0d: expected %p predicted %p",
                        i, directed_rows[i].want, got);
                end
            end
        end
        // Undo the predictor probe: typed rows are re-predicted at acceptance.
        clear_image();
        foreach (directed_rows[i]) send_beat(directed_rows[i].cmd);
        drain_results();

        // Random sessions across several register settings.
        for (int phase = 0; phase < 6; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_register(CFG_BASE, 32'h0001_0000);
                    write_register(CFG_CAP, 32'h0000_FFFF);
                end
                1: write_register(CFG_BASE, 32'hFFFF_FFF0);
                2: begin
                    write_register(CFG_BASE, 32'h0000_0001);
                    write_register(CFG_CAP, 32'd0);
                end
                3: begin
                    write_register(CFG_BASE, 32'hFFFF_FFFF);
                    write_register(CFG_CAP, 32'd64);
                end
                4: begin
                    write_register(CFG_BASE, $urandom);
                    write_register(CFG_CAP, 32'($urandom_range(40, 400)));
                end
                default: begin
                    write_register(CFG_BASE, 32'h8000_0000);
                    write_register(CFG_CAP, 32'h0000_FFFF);
                end
            endcase
            for (int s = 0; s < 5; s++) run_session((s == 4) ? 40 : 10);
        end

        // Too many arguments, and a long backslash run.
        drain_results();
        send_op(OP_START, 0);
        for (int i = 0; i < 66; i++) begin
            send_op(OP_LINE, 8'h62);
            send_op(OP_LINE, CH_SPC);
        end
        send_op(OP_START, 0);
        send_op(OP_LINE, CH_SPC);
        for (int i = 0; i < 20; i++) send_op(OP_LINE, CH_BSL);
        send_op(OP_LINE, 8'h7A);
        send_op(OP_FIN, 0);
        send_op(OP_READ, 0, 13'd12);

        drain_results();
        repeat (20) @(negedge i_clk);
        $display("Ran %0d result beats over directed rows and random parse sessions",
            beats_seen);
        $display("Covered quoting, backslash runs, env strings, limits, and reads");
        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Verification failed");
        end
        $finish;
    end
endmodule
